@@ sv/grbb_pkg.sv @@
// Shared types and constants for the group relabel bounding-box block.
// Used by grbb_ctrl, grbb_dpath and group_relabel_bounding_box.
package grbb_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_GRID_COLS   = 128;
    localparam int DEF_GRID_ROWS   = 128;
    localparam int DEF_COORD_LIMIT = 4096;

    // Fixed field widths
    localparam int LABEL_W   = 9;
    localparam int AREA_W    = 3;
    localparam int QUERY_W   = 7;
    localparam int BOX_W     = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    // Wide enough to compare any group index against a grid size up to 1024
    localparam int IDX_CMP_W = 11;
    // Wide enough for row * GRID_COLS + col before truncation to the address
    localparam int ADDR_CALC_W = 20;

    localparam int GROUP_SHIFT  = 2;
    localparam int RESET_CORNER = 3279;
    localparam int RESET_SIZE   = 3280;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;   // write one reset entry and advance the sweep
        logic load;    // capture the item at the input ports
        logic read;    // read the table entry of the captured item
        logic update;  // merge, write back and present the result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;  // sweep is at the last entry
    } t_sts;

endpackage

@@ sv/grbb_ctrl.sv @@
// Controller state machine for the group relabel bounding-box block.
// Depends on grbb_pkg for the state and command/status types.
module grbb_ctrl import grbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/grbb_dpath.sv @@
// Datapath of the group relabel bounding-box block: config registers,
// raster position, box table memory, merge logic and result registers.
// Depends on grbb_pkg for widths, constants and command/status types.
module grbb_dpath import grbb_pkg::*; #(
    parameter int GRID_COLS   = DEF_GRID_COLS,
    parameter int GRID_ROWS   = DEF_GRID_ROWS,
    parameter int COORD_LIMIT = DEF_COORD_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_action,
    input  logic [LABEL_W-1:0]   i_gen_col,
    input  logic [LABEL_W-1:0]   i_gen_row,
    input  logic [AREA_W-1:0]    i_area_num,
    input  logic [QUERY_W-1:0]   i_query_col,
    input  logic [QUERY_W-1:0]   i_query_row,
    output logic                 o_valid,
    output logic [LABEL_W-1:0]   o_label_col,
    output logic [LABEL_W-1:0]   o_label_row,
    output logic [AREA_W-1:0]    o_label_area,
    output logic [BOX_W-1:0]     o_box_left,
    output logic [BOX_W-1:0]     o_box_top,
    output logic [BOX_W-1:0]     o_box_right,
    output logic [BOX_W-1:0]     o_box_bottom,
    output logic                 o_box_empty,
    output logic                 o_out_of_grid
);

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COORD_LIMIT);
    // Stored coordinate width: holds raster positions and the reset corner
    localparam int EW    = (CW > BOX_W) ? CW : BOX_W;
    // Width for the wrap compare of position + 1 against a size register
    localparam int XW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    typedef struct packed {
        logic [EW-1:0] left;
        logic [EW-1:0] top;
        logic [EW-1:0] right;
        logic [EW-1:0] bottom;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{
        left:   EW'(RESET_CORNER),
        top:    EW'(RESET_CORNER),
        right:  '0,
        bottom: '0
    };

    t_entry r_mem [DEPTH];

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [CW-1:0]      r_x;
    logic [CW-1:0]      r_y;
    logic [AW-1:0]      r_clr_cnt;

    logic               r_action;
    logic [LABEL_W-1:0] r_gen_col;
    logic [LABEL_W-1:0] r_gen_row;
    logic [AREA_W-1:0]  r_area;
    logic               r_grouped;
    logic               r_oog;
    logic [AW-1:0]      r_addr;
    t_entry             r_rdata;

    logic               r_valid;
    logic [LABEL_W-1:0] r_label_col;
    logic [LABEL_W-1:0] r_label_row;
    logic [AREA_W-1:0]  r_label_area;
    logic [BOX_W-1:0]   r_box_left;
    logic [BOX_W-1:0]   r_box_top;
    logic [BOX_W-1:0]   r_box_right;
    logic [BOX_W-1:0]   r_box_bottom;
    logic               r_box_empty;
    logic               r_out_of_grid;

    // Group or query index of the incoming item, its grid check and table address
    logic [LABEL_W-1:0]     grp_col;
    logic [LABEL_W-1:0]     grp_row;
    logic [LABEL_W-1:0]     sel_col;
    logic [LABEL_W-1:0]     sel_row;
    logic                   in_grouped;
    logic                   in_oog;
    logic [ADDR_CALC_W-1:0] addr_full;

    always_comb begin
        grp_col    = i_gen_col >> GROUP_SHIFT;
        grp_row    = i_gen_row >> GROUP_SHIFT;
        in_grouped = (i_action == ACT_PIXEL) && (i_area_num == '0);
        if (i_action == ACT_READ) begin
            sel_col = LABEL_W'(i_query_col);
            sel_row = LABEL_W'(i_query_row);
        end else begin
            sel_col = grp_col;
            sel_row = grp_row;
        end
        in_oog = (IDX_CMP_W'(sel_col) >= IDX_CMP_W'(GRID_COLS))
              || (IDX_CMP_W'(sel_row) >= IDX_CMP_W'(GRID_ROWS));
        addr_full = ADDR_CALC_W'(sel_row) * ADDR_CALC_W'(GRID_COLS)
                  + ADDR_CALC_W'(sel_col);
    end

    // Merge the raster position into the read entry
    logic [EW-1:0] x_ext;
    logic [EW-1:0] y_ext;
    t_entry        merged;
    logic          do_write;

    always_comb begin
        x_ext         = EW'(r_x);
        y_ext         = EW'(r_y);
        merged        = r_rdata;
        if (x_ext < r_rdata.left)   merged.left   = x_ext;
        if (y_ext < r_rdata.top)    merged.top    = y_ext;
        if (x_ext > r_rdata.right)  merged.right  = x_ext;
        if (y_ext > r_rdata.bottom) merged.bottom = y_ext;
        do_write      = i_cmd.update && r_grouped && !r_oog;
    end

    // Raster advance
    logic [CW-1:0] x_next;
    logic [CW-1:0] y_next;
    logic          x_wrap;
    logic          y_wrap;

    always_comb begin
        x_wrap = (XW'(r_x) + XW'(1) >= XW'(r_width))
              || (r_x >= CW'(COORD_LIMIT - 1));
        y_wrap = (XW'(r_y) + XW'(1) >= XW'(r_height))
              || (r_y >= CW'(COORD_LIMIT - 1));
        x_next = r_x;
        y_next = r_y;
        if (x_wrap) begin
            x_next = '0;
            y_next = y_wrap ? '0 : r_y + CW'(1);
        end else begin
            x_next = r_x + CW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == AW'(DEPTH - 1));

    // Table write: clearing sweep or merged entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_cnt] <= RESET_ENTRY;
        end else if (do_write) begin
            r_mem[r_addr] <= merged;
        end
    end

    // Table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // Control state: config, raster position, sweep counter, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= CFG_W'(RESET_SIZE);
            r_height  <= CFG_W'(RESET_SIZE);
            r_x       <= '0;
            r_y       <= '0;
            r_clr_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.update && r_action == ACT_PIXEL) begin
                r_x <= x_next;
                r_y <= y_next;
            end
            r_valid <= i_cmd.update;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_gen_col <= i_gen_col;
            r_gen_row <= i_gen_row;
            r_area    <= i_area_num;
            r_grouped <= in_grouped;
            r_oog     <= (i_action == ACT_READ || in_grouped) ? in_oog : 1'b0;
            r_addr    <= addr_full[AW-1:0];
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_of_grid <= r_oog;
            if (r_action == ACT_READ) begin
                r_label_col  <= '0;
                r_label_row  <= '0;
                r_label_area <= '0;
                if (r_oog) begin
                    r_box_left   <= '0;
                    r_box_top    <= '0;
                    r_box_right  <= '0;
                    r_box_bottom <= '0;
                    r_box_empty  <= 1'b1;
                end else begin
                    r_box_left   <= r_rdata.left[BOX_W-1:0];
                    r_box_top    <= r_rdata.top[BOX_W-1:0];
                    r_box_right  <= r_rdata.right[BOX_W-1:0];
                    r_box_bottom <= r_rdata.bottom[BOX_W-1:0];
                    r_box_empty  <= (r_rdata.left > r_rdata.right);
                end
            end else begin
                r_label_col  <= r_grouped ? (r_gen_col >> GROUP_SHIFT) : r_gen_col;
                r_label_row  <= r_grouped ? (r_gen_row >> GROUP_SHIFT) : r_gen_row;
                r_label_area <= r_area;
                r_box_left   <= '0;
                r_box_top    <= '0;
                r_box_right  <= '0;
                r_box_bottom <= '0;
                r_box_empty  <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_label_col   = r_label_col;
    assign o_label_row   = r_label_row;
    assign o_label_area  = r_label_area;
    assign o_box_left    = r_box_left;
    assign o_box_top     = r_box_top;
    assign o_box_right   = r_box_right;
    assign o_box_bottom  = r_box_bottom;
    assign o_box_empty   = r_box_empty;
    assign o_out_of_grid = r_out_of_grid;

endmodule

@@ sv/group_relabel_bounding_box.sv @@
// o_valid rises after the edge that accepts an item, once the item has gone through
// capture, registered memory read, and merge and write back. busy stays high meanwhile,
// so a new item is taken only when the table read-modify-write of the last one is done.
// Reset: synchronous, active low; afterwards busy stays high while the box table is cleared.
// Results are strobed for one cycle and cannot be held off by the receiver.
module group_relabel_bounding_box import grbb_pkg::*; #(
    parameter int GRID_COLS   = DEF_GRID_COLS,
    parameter int GRID_ROWS   = DEF_GRID_ROWS,
    parameter int COORD_LIMIT = DEF_COORD_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_action,
    input  logic [LABEL_W-1:0]   i_gen_col,
    input  logic [LABEL_W-1:0]   i_gen_row,
    input  logic [AREA_W-1:0]    i_area_num,
    input  logic [QUERY_W-1:0]   i_query_col,
    input  logic [QUERY_W-1:0]   i_query_row,
    output logic                 o_valid,
    output logic [LABEL_W-1:0]   o_label_col,
    output logic [LABEL_W-1:0]   o_label_row,
    output logic [AREA_W-1:0]    o_label_area,
    output logic [BOX_W-1:0]     o_box_left,
    output logic [BOX_W-1:0]     o_box_top,
    output logic [BOX_W-1:0]     o_box_right,
    output logic [BOX_W-1:0]     o_box_bottom,
    output logic                 o_box_empty,
    output logic                 o_out_of_grid
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each item and the clearing sweep
    grbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Table, raster position and result registers
    grbb_dpath #(
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .COORD_LIMIT (COORD_LIMIT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_gen_col     (i_gen_col),
        .i_gen_row     (i_gen_row),
        .i_area_num    (i_area_num),
        .i_query_col   (i_query_col),
        .i_query_row   (i_query_row),
        .o_valid       (o_valid),
        .o_label_col   (o_label_col),
        .o_label_row   (o_label_row),
        .o_label_area  (o_label_area),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_right   (o_box_right),
        .o_box_bottom  (o_box_bottom),
        .o_box_empty   (o_box_empty),
        .o_out_of_grid (o_out_of_grid)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for group_relabel_bounding_box: sends label and box read items,
// predicts the relabeled label and the group box of every item, and compares each strobe.
// Depends on grbb_pkg and the block's RTL; needs no files or arguments.
module tb_top;
    import grbb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PRINT_CAP    = 60;
    localparam int GRID_CELLS   = DEF_GRID_COLS * DEF_GRID_ROWS;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;
    localparam logic [AREA_W-1:0]    AREA_CENTRAL = 3'd0;
    localparam logic [CFG_W-1:0]     SIZE_MAX     = 13'h1FFF;

    typedef struct packed {
        logic               action;
        logic [LABEL_W-1:0] gen_col;
        logic [LABEL_W-1:0] gen_row;
        logic [AREA_W-1:0]  area_num;
        logic [QUERY_W-1:0] query_col;
        logic [QUERY_W-1:0] query_row;
    } t_label_item;

    typedef struct packed {
        logic [LABEL_W-1:0] label_col;
        logic [LABEL_W-1:0] label_row;
        logic [AREA_W-1:0]  label_area;
        logic [BOX_W-1:0]   box_left;
        logic [BOX_W-1:0]   box_top;
        logic [BOX_W-1:0]   box_right;
        logic [BOX_W-1:0]   box_bottom;
        logic               box_empty;
        logic               out_of_grid;
    } t_label_result;

    // Block ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_action    = 1'b0;
    logic [LABEL_W-1:0]   i_gen_col   = '0;
    logic [LABEL_W-1:0]   i_gen_row   = '0;
    logic [AREA_W-1:0]    i_area_num  = '0;
    logic [QUERY_W-1:0]   i_query_col = '0;
    logic [QUERY_W-1:0]   i_query_row = '0;
    logic                 o_valid;
    logic [LABEL_W-1:0]   o_label_col;
    logic [LABEL_W-1:0]   o_label_row;
    logic [AREA_W-1:0]    o_label_area;
    logic [BOX_W-1:0]     o_box_left;
    logic [BOX_W-1:0]     o_box_top;
    logic [BOX_W-1:0]     o_box_right;
    logic [BOX_W-1:0]     o_box_bottom;
    logic                 o_box_empty;
    logic                 o_out_of_grid;

    // Tracked copy of the box table, raster position and image size
    logic [BOX_W-1:0] box_left_tbl   [GRID_CELLS];
    logic [BOX_W-1:0] box_top_tbl    [GRID_CELLS];
    logic [BOX_W-1:0] box_right_tbl  [GRID_CELLS];
    logic [BOX_W-1:0] box_bottom_tbl [GRID_CELLS];
    logic [BOX_W-1:0] pos_x;
    logic [BOX_W-1:0] pos_y;
    logic [CFG_W-1:0] img_width;
    logic [CFG_W-1:0] img_height;

    t_label_result queued_label_results[$];
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    bit            idle_off       = 1'b0;

    group_relabel_bounding_box dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_gen_col    (i_gen_col),
        .i_gen_row    (i_gen_row),
        .i_area_num   (i_area_num),
        .i_query_col  (i_query_col),
        .i_query_row  (i_query_row),
        .o_valid      (o_valid),
        .o_label_col  (o_label_col),
        .o_label_row  (o_label_row),
        .o_label_area (o_label_area),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_right  (o_box_right),
        .o_box_bottom (o_box_bottom),
        .o_box_empty  (o_box_empty),
        .o_out_of_grid(o_out_of_grid)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Relabel one item, widen or read its group box, and step the raster
    function automatic t_label_result relabel_and_track(input t_label_item it);
        t_label_result res;
        int            gcol;
        int            grow;
        int            slot;
        res = '0;
        if (it.action == ACT_READ) begin
            if (int'(it.query_col) >= DEF_GRID_COLS || int'(it.query_row) >= DEF_GRID_ROWS) begin
                res.box_empty   = 1'b1;
                res.out_of_grid = 1'b1;
            end else begin
                slot           = int'(it.query_row) * DEF_GRID_COLS + int'(it.query_col);
                res.box_left   = box_left_tbl[slot];
                res.box_top    = box_top_tbl[slot];
                res.box_right  = box_right_tbl[slot];
                res.box_bottom = box_bottom_tbl[slot];
                res.box_empty  = (box_left_tbl[slot] > box_right_tbl[slot]);
            end
            return res;
        end
        if (it.area_num == AREA_CENTRAL) begin
            gcol          = int'(it.gen_col) >> GROUP_SHIFT;
            grow          = int'(it.gen_row) >> GROUP_SHIFT;
            res.label_col = LABEL_W'(gcol);
            res.label_row = LABEL_W'(grow);
            if (gcol >= DEF_GRID_COLS || grow >= DEF_GRID_ROWS) begin
                res.out_of_grid = 1'b1;
            end else begin
                slot = grow * DEF_GRID_COLS + gcol;
                if (pos_x < box_left_tbl[slot])   box_left_tbl[slot]   = pos_x;
                if (pos_y < box_top_tbl[slot])    box_top_tbl[slot]    = pos_y;
                if (pos_x > box_right_tbl[slot])  box_right_tbl[slot]  = pos_x;
                if (pos_y > box_bottom_tbl[slot]) box_bottom_tbl[slot] = pos_y;
            end
        end else begin
            res.label_col = it.gen_col;
            res.label_row = it.gen_row;
        end
        res.label_area = it.area_num;
        // Advance the raster, wrapping on the image size or the coordinate limit
        if (int'(pos_x) + 1 >= int'(img_width) || int'(pos_x) >= DEF_COORD_LIMIT - 1) begin
            pos_x = '0;
            if (int'(pos_y) + 1 >= int'(img_height) || int'(pos_y) >= DEF_COORD_LIMIT - 1)
                pos_y = '0;
            else
                pos_y = pos_y + 1'b1;
        end else begin
            pos_x = pos_x + 1'b1;
        end
        return res;
    endfunction

    function automatic t_label_item make_pixel(input int col, input int row, input int area);
        t_label_item it;
        it          = '0;
        it.action   = ACT_PIXEL;
        it.gen_col  = LABEL_W'(col);
        it.gen_row  = LABEL_W'(row);
        it.area_num = AREA_W'(area);
        return it;
    endfunction

    function automatic t_label_item make_read(input int qcol, input int qrow);
        t_label_item it;
        it           = '0;
        it.action    = ACT_READ;
        it.query_col = QUERY_W'(qcol);
        it.query_row = QUERY_W'(qrow);
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Present one item, hold it until accepted, then queue its prediction
    task automatic send_item(input t_label_item it);
        if (!idle_off && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= it.action;
        i_gen_col   <= it.gen_col;
        i_gen_row   <= it.gen_row;
        i_area_num  <= it.area_num;
        i_query_col <= it.query_col;
        i_query_row <= it.query_row;
        do @(posedge i_clk); while (busy !== 1'b0);
        queued_label_results.push_back(relabel_and_track(it));
    endtask

    // Drop start and wait until every queued result has come back
    task automatic settle_block();
        start <= 1'b0;
        while (queued_label_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write width, height and one spare index that the block must ignore
    task automatic program_size(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        for (int n = 0; n < 3; n++) begin
            case (n)
                0: begin
                    idx  = REG_IMAGE_WIDTH;
                    data = width;
                end
                1: begin
                    idx  = REG_IMAGE_HEIGHT;
                    data = height;
                end
                default: begin
                    idx  = $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
                    data = CFG_W'($urandom);
                end
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
            if (idx == REG_IMAGE_WIDTH)
                img_width = data;
            else if (idx == REG_IMAGE_HEIGHT)
                img_height = data;
        end
        i_cfg_we <= 1'b0;
    endtask

    // Empty reads, field extremes, every area and group merging at reset size
    task automatic test_directed_labels();
        send_item(make_read(0, 0));
        send_item(make_read(127, 127));
        send_item(make_read(127, 0));
        send_item(make_pixel(0, 0, 0));
        send_item(make_pixel(511, 511, 0));
        send_item(make_pixel(3, 3, 0));
        for (int a = 1; a < 8; a++)
            send_item(make_pixel((a % 2) ? 511 : 0, (a % 3) ? 0 : 511, a));
        send_item(make_pixel(2, 1, 0));
        send_item(make_read(0, 0));
        send_item(make_read(127, 127));
        send_item(make_read(1, 0));
    endtask

    // Image sizes of zero, one, the coordinate limit, the field maximum and two by three
    task automatic test_register_extremes();
        logic [CFG_W-1:0] sizes [5][2];
        sizes = '{'{13'd0, 13'd0}, '{13'd1, 13'd1}, '{13'd4096, 13'd4096},
                  '{SIZE_MAX, SIZE_MAX}, '{13'd2, 13'd3}};
        for (int s = 0; s < 5; s++) begin
            settle_block();
            program_size(sizes[s][0], sizes[s][1]);
            send_item(make_pixel($urandom_range(4, 7), $urandom_range(4, 7), 0));
            send_item(make_pixel($urandom_range(4, 7), $urandom_range(4, 7), 0));
            send_item(make_read(1, 1));
        end
    endtask

    // Small images with clustered groups, reads of nearby groups and noise
    task automatic test_random_raster();
        int base_col;
        int base_row;
        int pick;
        for (int phase = 0; phase < 6; phase++) begin
            settle_block();
            program_size(CFG_W'($urandom_range(1, 48)), CFG_W'($urandom_range(1, 24)));
            base_col = $urandom_range(0, 480);
            base_row = $urandom_range(0, 480);
            // Run one whole phase back to back with no idle gaps
            idle_off = (phase == 3);
            for (int n = 0; n < 145; n++) begin
                // Hold off once mid-phase until the pipeline is empty
                if (phase == 2 && n == 72)
                    settle_block();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_item(make_pixel(base_col + $urandom_range(0, 31),
                                         base_row + $urandom_range(0, 31), 0));
                else if (pick < 75)
                    send_item(make_pixel($urandom_range(0, 511), $urandom_range(0, 511),
                                         $urandom_range(0, 7)));
                else if (pick < 92)
                    send_item(make_read((base_col >> GROUP_SHIFT) + $urandom_range(0, 7),
                                        (base_row >> GROUP_SHIFT) + $urandom_range(0, 7)));
                else
                    send_item(make_read($urandom_range(0, 127), $urandom_range(0, 127)));
            end
        end
        idle_off = 1'b0;
    endtask

    // Compare each strobed result with the oldest queued prediction
    always @(posedge i_clk) begin
        t_label_result want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (queued_label_results.size() == 0) begin
                report_mismatch("result strobe with no item outstanding");
            end else begin
                want = queued_label_results.pop_front();
                if (o_valid !== 1'b1)
                    report_mismatch("o_valid is unknown");
                if (o_label_col !== want.label_col)
                    report_mismatch($sformatf("label_col got %0d want %0d",
                                              o_label_col, want.label_col));
                if (o_label_row !== want.label_row)
                    report_mismatch($sformatf("label_row got %0d want %0d",
                                              o_label_row, want.label_row));
                if (o_label_area !== want.label_area)
                    report_mismatch($sformatf("label_area got %0d want %0d",
                                              o_label_area, want.label_area));
                if (o_box_left !== want.box_left)
                    report_mismatch($sformatf("box_left got %0d want %0d",
                                              o_box_left, want.box_left));
                if (o_box_top !== want.box_top)
                    report_mismatch($sformatf("box_top got %0d want %0d",
                                              o_box_top, want.box_top));
                if (o_box_right !== want.box_right)
                    report_mismatch($sformatf("box_right got %0d want %0d",
                                              o_box_right, want.box_right));
                if (o_box_bottom !== want.box_bottom)
                    report_mismatch($sformatf("box_bottom got %0d want %0d",
                                              o_box_bottom, want.box_bottom));
                if (o_box_empty !== want.box_empty)
                    report_mismatch($sformatf("box_empty got %0d want %0d",
                                              o_box_empty, want.box_empty));
                if (o_out_of_grid !== want.out_of_grid)
                    report_mismatch($sformatf("out_of_grid got %0d want %0d",
                                              o_out_of_grid, want.out_of_grid));
            end
        end
    end

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < GRID_CELLS; k++) begin
            box_left_tbl[k]   = BOX_W'(RESET_CORNER);
            box_top_tbl[k]    = BOX_W'(RESET_CORNER);
            box_right_tbl[k]  = '0;
            box_bottom_tbl[k] = '0;
        end
        pos_x      = '0;
        pos_y      = '0;
        img_width  = CFG_W'(RESET_SIZE);
        img_height = CFG_W'(RESET_SIZE);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed_labels();
        test_register_extremes();
        test_random_raster();
        settle_block();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/grbb_pkg.sv
sv/grbb_ctrl.sv
sv/grbb_dpath.sv
sv/group_relabel_bounding_box.sv
tb/tb_top.sv
